@@ rtl/assert_macros.svh @@
// assertion macros used by the core rtl file
// depends on nothing; clock and reset are passed in by the user
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising edge, quiet during reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition that must never hold
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

@@ rtl/btbl_pkg.sv @@
// types, codes and constants of the ballistic table lookup
// used by the core and the testbench; depends on nothing
`timescale 1ns / 1ps

package btbl_pkg;

    localparam int DEF_MAX_COLS = 64;
    localparam int DEF_MAX_ROWS = 64;
    localparam int CNT_W        = 11;
    localparam int ENTRY_W      = 64;

    localparam logic signed [31:0] TIME_MIN_Q = 32'sd655;
    localparam logic signed [31:0] TIME_MAX_Q = 32'sd655360;
    localparam logic signed [32:0] WIDEN_Q    = 33'sd11438;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [2:0] REG_ORIGIN_DIST   = 3'd0;
    localparam logic [2:0] REG_ORIGIN_HEIGHT = 3'd1;
    localparam logic [2:0] REG_INV_STEP_DIST = 3'd2;
    localparam logic [2:0] REG_INV_STEP_HGT  = 3'd3;
    localparam logic [2:0] REG_COLS_USED     = 3'd4;
    localparam logic [2:0] REG_ROWS_USED     = 3'd5;
    localparam logic [2:0] REG_ANGLE_LOW     = 3'd6;
    localparam logic [2:0] REG_ANGLE_HIGH    = 3'd7;

    localparam logic [2:0] RGN_INTERIOR    = 3'd0;
    localparam logic [2:0] RGN_LOW_CORNER  = 3'd1;
    localparam logic [2:0] RGN_HIGH_CORNER = 3'd2;
    localparam logic [2:0] RGN_DIST_BELOW  = 3'd3;
    localparam logic [2:0] RGN_DIST_ABOVE  = 3'd4;
    localparam logic [2:0] RGN_HGT_BELOW   = 3'd5;
    localparam logic [2:0] RGN_HGT_ABOVE   = 3'd6;

    typedef struct packed {
        logic               opcode;
        logic [5:0]         dist_index;
        logic [5:0]         height_index;
        logic signed [31:0] entry_angle;
        logic signed [31:0] entry_time;
        logic signed [31:0] target_dist;
        logic signed [31:0] target_height;
    } t_cmd;

    typedef struct packed {
        logic signed [31:0] pitch_angle;
        logic signed [31:0] flight_time;
        logic [2:0]         region;
    } t_res;

endpackage

@@ rtl/btbl_ram.sv @@
// generic simple dual port ram, one write port, one registered read port
// depends on nothing
`timescale 1ns / 1ps

module btbl_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/ballistic_table_bilinear_lookup_core.sv @@
// top level of the ballistic table lookup: config registers, pipeline, grid banks
// depends on btbl_pkg, btbl_ram and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Takes one item per clock while o_stall is low and answers a query through stages
// one to six and the output register; write items load a grid entry and give no beat out.
// The grid sits in four RAM banks split by column and row parity, so the four
// neighbors of any point are read in the same cycle from the single read port of each
// bank. Grid entries come up undefined after reset and must be written before they
// are queried; there is no clearing pass. Config writes are always ready and are
// meant to happen only while the pipeline is empty.
module ballistic_table_bilinear_lookup_core
    import btbl_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_cmd        i_cmd,
    output logic        o_valid,
    input  logic        i_stall,
    output t_res        o_res,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int CIW   = $clog2(MAX_COLS);
    localparam int RIW   = $clog2(MAX_ROWS);
    localparam int RB    = (MAX_ROWS + 1) / 2;
    localparam int DEPTH = ((MAX_COLS + 1) / 2) * RB;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // config
    logic signed [31:0] r_origin_dist, r_origin_height, r_angle_low, r_angle_high;
    logic [30:0]        r_inv_dist, r_inv_height;
    logic [6:0]         r_cols_used, r_rows_used;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_dist   <= '0;
            r_origin_height <= '0;
            r_inv_dist      <= 31'd65536;
            r_inv_height    <= 31'd65536;
            r_cols_used     <= 7'd64;
            r_rows_used     <= 7'd64;
            r_angle_low     <= '0;
            r_angle_high    <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_ORIGIN_DIST:   r_origin_dist   <= i_cfg_data;
                REG_ORIGIN_HEIGHT: r_origin_height <= i_cfg_data;
                REG_INV_STEP_DIST: r_inv_dist      <= i_cfg_data[30:0];
                REG_INV_STEP_HGT:  r_inv_height    <= i_cfg_data[30:0];
                REG_COLS_USED:     r_cols_used     <= i_cfg_data[6:0];
                REG_ROWS_USED:     r_rows_used     <= i_cfg_data[6:0];
                REG_ANGLE_LOW:     r_angle_low     <= i_cfg_data;
                REG_ANGLE_HIGH:    r_angle_high    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    function automatic logic [CNT_W-1:0] clamp_cnt(input logic [6:0] n, input int mx);
        logic [CNT_W-1:0] res;
        if (n < 7'd2) begin
            res = CNT_W'(2);
        end else if (int'(n) > mx) begin
            res = CNT_W'(mx);
        end else begin
            res = CNT_W'(n);
        end
        return res;
    endfunction

    function automatic logic [AW-1:0] bank_addr(input logic [CIW-1:0] col,
                                                input logic [RIW-1:0] row);
        return AW'(col >> 1) * AW'(RB) + AW'(row >> 1);
    endfunction

    // pipeline handshake
    logic r1_v, r2_v, r3_v, r4_v, r5_v, r6_v, r_ov;
    logic w_en1, w_en2, w_en3, w_en4, w_en5, w_en6, w_eno;
    t_cmd r1_cmd, r2_cmd;

    assign w_eno = !r_ov || !i_stall;
    assign w_en6 = !r6_v || w_eno;
    assign w_en5 = !r5_v || w_en6;
    assign w_en4 = !r4_v || w_en5;
    assign w_en3 = !r3_v || w_en4;
    assign w_en2 = !r2_v || w_en3;
    assign w_en1 = !r1_v || w_en2;
    assign o_stall = !w_en1;
    assign o_valid = r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (w_en1) r1_v <= i_valid;
            if (w_en2) r2_v <= r1_v;
            if (w_en3) r3_v <= r2_v && (r2_cmd.opcode == OP_QUERY);
            if (w_en4) r4_v <= r3_v;
            if (w_en5) r5_v <= r4_v;
            if (w_en6) r6_v <= r5_v;
            if (w_eno) r_ov <= r6_v;
        end
    end

    // stage 1: offsets from origin
    logic signed [32:0] r1_dfx, r1_dfy;

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r1_cmd <= i_cmd;
            r1_dfx <= $signed({i_cmd.target_dist[31], i_cmd.target_dist})
                    - $signed({r_origin_dist[31], r_origin_dist});
            r1_dfy <= $signed({i_cmd.target_height[31], i_cmd.target_height})
                    - $signed({r_origin_height[31], r_origin_height});
        end
    end

    // stage 2: grid coordinates in q.16 steps
    logic signed [47:0] r2_px, r2_py;
    logic signed [64:0] w_prodx, w_prody;

    assign w_prodx = r1_dfx * $signed({1'b0, r_inv_dist});
    assign w_prody = r1_dfy * $signed({1'b0, r_inv_height});

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r2_cmd <= r1_cmd;
            r2_px  <= w_prodx[63:16];
            r2_py  <= w_prody[63:16];
        end
    end

    // stage 3: region, base point, bank reads or grid write
    logic [CNT_W-1:0]   w_nc, w_nr;
    logic signed [47:0] w_hx, w_hy, w_offx, w_offy;
    logic               w_xl, w_xh, w_yl, w_yh;
    logic [CIW-1:0]     w_i, w_ncm1, w_ncm2, w_cb, w_cb_p1, w_wc;
    logic [RIW-1:0]     w_j, w_nrm1, w_nrm2, w_rb, w_rb_p1, w_wr;
    logic [2:0]         w_region;
    logic signed [47:0] w_ratio;
    logic               w_rd_go, w_wr_go, w_any_re, w_any_we;
    logic [3:0]         w_re, w_we;
    logic [ENTRY_W-1:0] w_rd [4];

    assign w_nc   = clamp_cnt(r_cols_used, MAX_COLS);
    assign w_nr   = clamp_cnt(r_rows_used, MAX_ROWS);
    assign w_hx   = $signed({21'b0, w_nc - 11'd1, 16'b0});
    assign w_hy   = $signed({21'b0, w_nr - 11'd1, 16'b0});
    assign w_offx = $signed({21'b0, w_nc - 11'd2, 16'b0});
    assign w_offy = $signed({21'b0, w_nr - 11'd2, 16'b0});
    assign w_xl   = r2_px < 48'sd0;
    assign w_xh   = r2_px >= w_hx;
    assign w_yl   = r2_py < 48'sd0;
    assign w_yh   = r2_py >= w_hy;
    assign w_i    = r2_px[16 +: CIW];
    assign w_j    = r2_py[16 +: RIW];
    assign w_ncm1 = CIW'(w_nc - 11'd1);
    assign w_ncm2 = CIW'(w_nc - 11'd2);
    assign w_nrm1 = RIW'(w_nr - 11'd1);
    assign w_nrm2 = RIW'(w_nr - 11'd2);

    always_comb begin
        w_region = RGN_INTERIOR;
        w_cb     = w_i;
        w_rb     = w_j;
        w_ratio  = '0;
        if (w_xl && w_yl) begin
            w_region = RGN_LOW_CORNER;
            w_cb     = '0;
            w_rb     = '0;
        end else if (w_xh && w_yh) begin
            w_region = RGN_HIGH_CORNER;
            w_cb     = w_ncm1;
            w_rb     = w_nrm1;
        end else if (w_xl || w_xh) begin
            w_region = w_xl ? RGN_DIST_BELOW : RGN_DIST_ABOVE;
            w_cb     = w_xl ? '0 : w_ncm2;
            w_rb     = w_yl ? '0 : (w_yh ? w_nrm1 : w_j);
            w_ratio  = w_xl ? r2_px : r2_px - w_offx;
        end else if (w_yl || w_yh) begin
            w_region = w_yl ? RGN_HGT_BELOW : RGN_HGT_ABOVE;
            w_rb     = w_yl ? '0 : w_nrm2;
            w_ratio  = w_yl ? r2_py : r2_py - w_offy;
        end
    end

    assign w_cb_p1 = (w_cb == CIW'(MAX_COLS - 1)) ? w_cb : w_cb + 1'b1;
    assign w_rb_p1 = (w_rb == RIW'(MAX_ROWS - 1)) ? w_rb : w_rb + 1'b1;
    assign w_wc    = CIW'(r2_cmd.dist_index);
    assign w_wr    = RIW'(r2_cmd.height_index);
    assign w_rd_go = w_en3 && r2_v && (r2_cmd.opcode == OP_QUERY);
    assign w_wr_go = w_en3 && r2_v && (r2_cmd.opcode == OP_WRITE)
                  && (int'(r2_cmd.dist_index) < MAX_COLS)
                  && (int'(r2_cmd.height_index) < MAX_ROWS);
    assign w_any_re = |w_re;
    assign w_any_we = |w_we;

    for (genvar b = 0; b < 4; b++) begin : g_bank
        localparam logic PC = 1'((b >> 1) & 1);
        localparam logic PR = 1'(b & 1);
        logic [CIW-1:0] w_col;
        logic [RIW-1:0] w_row;

        assign w_col = (w_cb[0] == PC) ? w_cb : w_cb_p1;
        assign w_row = (w_rb[0] == PR) ? w_rb : w_rb_p1;
        assign w_re[b] = w_rd_go;
        assign w_we[b] = w_wr_go && (w_wc[0] == PC) && (w_wr[0] == PR);

        btbl_ram #(
            .WIDTH (ENTRY_W),
            .DEPTH (DEPTH),
            .AW    (AW)
        ) u_bank (
            .i_clk   (i_clk),
            .i_we    (w_we[b]),
            .i_waddr (bank_addr(w_wc, w_wr)),
            .i_wdata ({r2_cmd.entry_angle, r2_cmd.entry_time}),
            .i_re    (w_re[b]),
            .i_raddr (bank_addr(w_col, w_row)),
            .o_rdata (w_rd[b])
        );
    end

    logic [2:0]         r3_region;
    logic               r3_cb0, r3_rb0;
    logic [15:0]        r3_fx, r3_fy;
    logic signed [47:0] r3_ratio;

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r3_region <= w_region;
            r3_cb0    <= w_cb[0];
            r3_rb0    <= w_rb[0];
            r3_fx     <= r2_px[15:0];
            r3_fy     <= r2_py[15:0];
            r3_ratio  <= w_ratio;
        end
    end

    // stage 4: first products
    logic [ENTRY_W-1:0] w_v00, w_v10, w_v01, w_v11, w_v1;
    logic signed [31:0] w_a00, w_a10, w_a01, w_a11, w_t00, w_t10, w_t01, w_t11;
    logic signed [31:0] w_a1, w_t1;
    logic [16:0]        w_ex;
    logic signed [32:0] w_da, w_dt;

    assign w_v00 = w_rd[{r3_cb0, r3_rb0}];
    assign w_v10 = w_rd[{~r3_cb0, r3_rb0}];
    assign w_v01 = w_rd[{r3_cb0, ~r3_rb0}];
    assign w_v11 = w_rd[{~r3_cb0, ~r3_rb0}];
    assign {w_a00, w_t00} = w_v00;
    assign {w_a10, w_t10} = w_v10;
    assign {w_a01, w_t01} = w_v01;
    assign {w_a11, w_t11} = w_v11;
    assign w_v1 = (r3_region == RGN_DIST_BELOW || r3_region == RGN_DIST_ABOVE) ? w_v10 : w_v01;
    assign {w_a1, w_t1} = w_v1;
    assign w_ex = 17'h10000 - {1'b0, r3_fx};
    assign w_da = $signed({w_a1[31], w_a1}) - $signed({w_a00[31], w_a00});
    assign w_dt = $signed({w_t1[31], w_t1}) - $signed({w_t00[31], w_t00});

    logic [2:0]         r4_region;
    logic [15:0]        r4_fy;
    logic signed [31:0] r4_a0, r4_t0;
    logic signed [49:0] r4_r0a, r4_r1a, r4_r0t, r4_r1t;
    logic signed [56:0] r4_pha, r4_pht;
    logic signed [57:0] r4_pla, r4_plt;

    always_ff @(posedge i_clk) begin
        if (w_en4) begin
            r4_region <= r3_region;
            r4_fy     <= r3_fy;
            r4_a0     <= w_a00;
            r4_t0     <= w_t00;
            r4_r0a <= w_a00 * $signed({1'b0, w_ex}) + w_a10 * $signed({2'b0, r3_fx});
            r4_r1a <= w_a01 * $signed({1'b0, w_ex}) + w_a11 * $signed({2'b0, r3_fx});
            r4_r0t <= w_t00 * $signed({1'b0, w_ex}) + w_t10 * $signed({2'b0, r3_fx});
            r4_r1t <= w_t01 * $signed({1'b0, w_ex}) + w_t11 * $signed({2'b0, r3_fx});
            r4_pha <= w_da * $signed(r3_ratio[47:24]);
            r4_pht <= w_dt * $signed(r3_ratio[47:24]);
            r4_pla <= w_da * $signed({1'b0, r3_ratio[23:0]});
            r4_plt <= w_dt * $signed({1'b0, r3_ratio[23:0]});
        end
    end

    // stage 5: second products, extrapolation step
    logic [16:0]        w_ey;
    logic signed [81:0] w_suma, w_sumt;
    logic signed [65:0] w_ma, w_mt;
    logic signed [33:0] w_ca, w_ct;

    assign w_ey   = 17'h10000 - {1'b0, r4_fy};
    assign w_suma = $signed({r4_pha, 24'b0}) + r4_pla;
    assign w_sumt = $signed({r4_pht, 24'b0}) + r4_plt;
    assign w_ma   = w_suma[81:16];
    assign w_mt   = w_sumt[81:16];
    assign w_ca   = (w_ma[65:33] == {33{w_ma[65]}}) ? w_ma[33:0]
                  : {w_ma[65], {33{~w_ma[65]}}};
    assign w_ct   = (w_mt[65:33] == {33{w_mt[65]}}) ? w_mt[33:0]
                  : {w_mt[65], {33{~w_mt[65]}}};

    logic [2:0]         r5_region;
    logic signed [31:0] r5_a0, r5_t0;
    logic signed [33:0] r5_ma, r5_mt;
    logic signed [67:0] r5_q0a, r5_q1a, r5_q0t, r5_q1t;

    always_ff @(posedge i_clk) begin
        if (w_en5) begin
            r5_region <= r4_region;
            r5_a0     <= r4_a0;
            r5_t0     <= r4_t0;
            r5_ma     <= w_ca;
            r5_mt     <= w_ct;
            r5_q0a    <= r4_r0a * $signed({1'b0, w_ey});
            r5_q1a    <= r4_r1a * $signed({2'b0, r4_fy});
            r5_q0t    <= r4_r0t * $signed({1'b0, w_ey});
            r5_q1t    <= r4_r1t * $signed({2'b0, r4_fy});
        end
    end

    // stage 6: bilinear sum, corner value or saturated lerp
    logic signed [68:0] w_bsa, w_bst;
    logic signed [34:0] w_ea, w_et;
    logic signed [31:0] w_sa, w_st, w_ang6, w_tim6;

    assign w_bsa = r5_q0a + r5_q1a;
    assign w_bst = r5_q0t + r5_q1t;
    assign w_ea  = r5_a0 + r5_ma;
    assign w_et  = r5_t0 + r5_mt;
    assign w_sa  = (w_ea[34:31] == {4{w_ea[34]}}) ? w_ea[31:0]
                 : {w_ea[34], {31{~w_ea[34]}}};
    assign w_st  = (w_et[34:31] == {4{w_et[34]}}) ? w_et[31:0]
                 : {w_et[34], {31{~w_et[34]}}};

    always_comb begin
        case (r5_region)
            RGN_INTERIOR: begin
                w_ang6 = w_bsa[63:32];
                w_tim6 = w_bst[63:32];
            end
            RGN_LOW_CORNER, RGN_HIGH_CORNER: begin
                w_ang6 = r5_a0;
                w_tim6 = r5_t0;
            end
            default: begin
                w_ang6 = w_sa;
                w_tim6 = w_st;
            end
        endcase
    end

    logic [2:0]         r6_region;
    logic signed [31:0] r6_ang, r6_tim;

    always_ff @(posedge i_clk) begin
        if (w_en6) begin
            r6_region <= r5_region;
            r6_ang    <= w_ang6;
            r6_tim    <= w_tim6;
        end
    end

    // output stage: per region clamps
    logic signed [32:0] w_lo, w_hi, w_ang33;
    logic signed [31:0] w_ango, w_timo;

    assign w_lo    = $signed({r_angle_low[31], r_angle_low}) - WIDEN_Q;
    assign w_hi    = $signed({r_angle_high[31], r_angle_high}) + WIDEN_Q;
    assign w_ang33 = $signed({r6_ang[31], r6_ang});

    always_comb begin
        w_ango = r6_ang;
        w_timo = r6_tim;
        case (r6_region)
            RGN_INTERIOR: begin
                if (r6_tim <= 32'sd0) begin
                    w_timo = TIME_MIN_Q;
                end else begin
                    if (r6_tim > TIME_MAX_Q) w_timo = TIME_MAX_Q;
                    if (w_ang33 > w_hi) begin
                        w_ango = w_hi[31:0];
                    end else if (w_ang33 < w_lo) begin
                        w_ango = (w_lo > w_hi) ? w_hi[31:0] : w_lo[31:0];
                    end
                end
            end
            RGN_DIST_BELOW, RGN_HGT_BELOW: begin
                if (r6_ang < r_angle_low) w_ango = r_angle_low;
                if (r6_tim < TIME_MIN_Q) w_timo = TIME_MIN_Q;
            end
            RGN_DIST_ABOVE: begin
                if (r6_ang > r_angle_high) w_ango = r_angle_high;
            end
            default: begin
            end
        endcase
    end

    t_res r_res;

    always_ff @(posedge i_clk) begin
        if (w_eno) begin
            r_res.pitch_angle <= w_ango;
            r_res.flight_time <= w_timo;
            r_res.region      <= r6_region;
        end
    end

    assign o_res = r_res;

    `ASSERT_NEVER(a_bank_rw_excl, i_clk, i_rst_n, w_any_re && w_any_we,
        "grid banks read and written in the same cycle")
    `ASSERT_IMPL(a_interior_time, i_clk, i_rst_n,
        o_valid && o_res.region == RGN_INTERIOR,
        o_res.flight_time > 32'sd0 && o_res.flight_time <= TIME_MAX_Q,
        "interior flight time out of clamp range")
    `ASSERT_IMPL(a_below_time, i_clk, i_rst_n,
        o_valid && (o_res.region == RGN_DIST_BELOW || o_res.region == RGN_HGT_BELOW),
        o_res.flight_time >= TIME_MIN_Q,
        "low side flight time below minimum")

endmodule

@@ dv/testbench.sv @@
// self-checking testbench for ballistic_table_bilinear_lookup_core
// a class scoreboard predicts every query beat; depends on btbl_pkg and the core rtl
`timescale 1ns / 1ps

module testbench;
    import btbl_pkg::*;

    localparam int CMD_W = $bits(t_cmd);

    class aim_table_model;
        int       angle_grid[4096];
        int       time_grid[4096];
        longint   org_d, org_h, inv_d, inv_h, n_cols, n_rows, ang_lo, ang_hi;
        t_res     pending_res[$];
        int       errors;

        function void clear_regs();
            org_d = 0; org_h = 0; inv_d = 65536; inv_h = 65536;
            n_cols = 64; n_rows = 64; ang_lo = 0; ang_hi = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] data);
            case (idx)
                REG_ORIGIN_DIST:   org_d = longint'($signed(data));
                REG_ORIGIN_HEIGHT: org_h = longint'($signed(data));
                REG_INV_STEP_DIST: inv_d = longint'(data[30:0]);
                REG_INV_STEP_HGT:  inv_h = longint'(data[30:0]);
                REG_COLS_USED:     n_cols = longint'(data[6:0]);
                REG_ROWS_USED:     n_rows = longint'(data[6:0]);
                REG_ANGLE_LOW:     ang_lo = longint'($signed(data));
                REG_ANGLE_HIGH:    ang_hi = longint'($signed(data));
                default: ;
            endcase
        endfunction

        function longint sat32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        // floored product over 2^16, magnitude capped at 2^56
        function longint mul_q16(longint a, longint b);
            bit neg;
            longint unsigned ua, ub, hi, lo, m, lim;
            lim = 64'd1 << 56;
            neg = (a < 0) != (b < 0);
            ua = (a < 0) ? -a : a;
            ub = (b < 0) ? -b : b;
            hi = ua * (ub >> 24);
            lo = ua * (ub & 64'hFFFFFF);
            if (hi >= (64'd1 << 48)) begin
                m = lim;
            end else begin
                m = (hi << 8) + (lo >> 16);
                if (neg && lo[15:0] != 0) m = m + 1;
                if (m > lim) m = lim;
            end
            return neg ? -longint'(m) : longint'(m);
        endfunction

        function longint lerp(longint v0, longint v1, longint ratio);
            return sat32(v0 + mul_q16(v1 - v0, ratio));
        endfunction

        function void note_cmd(t_cmd c);
            longint nc, nr, px, py, hx, hy, th, t, ratio, dx, dy, ex, ey, r0, r1;
            int     i, j, a, b;
            bit     xl, xh, yl, yh;
            t_res   r;
            if (c.opcode == OP_WRITE) begin
                angle_grid[c.dist_index * 64 + c.height_index] = c.entry_angle;
                time_grid[c.dist_index * 64 + c.height_index] = c.entry_time;
                return;
            end
            nc = (n_cols < 2) ? 2 : (n_cols > 64 ? 64 : n_cols);
            nr = (n_rows < 2) ? 2 : (n_rows > 64 ? 64 : n_rows);
            px = mul_q16(longint'(c.target_dist) - org_d, inv_d);
            py = mul_q16(longint'(c.target_height) - org_h, inv_h);
            hx = (nc - 1) <<< 16;
            hy = (nr - 1) <<< 16;
            xl = px < 0; xh = px >= hx; yl = py < 0; yh = py >= hy;
            if (xl && yl) begin
                th = angle_grid[0]; t = time_grid[0];
                r.region = RGN_LOW_CORNER;
            end else if (xh && yh) begin
                a = int'((nc - 1) * 64 + nr - 1);
                th = angle_grid[a]; t = time_grid[a];
                r.region = RGN_HIGH_CORNER;
            end else if (xl || xh) begin
                j = yl ? 0 : (yh ? int'(nr - 1) : int'(py >>> 16));
                i = xl ? 0 : int'(nc - 2);
                ratio = xl ? px : px - ((nc - 2) <<< 16);
                a = i * 64 + j; b = a + 64;
                th = lerp(angle_grid[a], angle_grid[b], ratio);
                t = lerp(time_grid[a], time_grid[b], ratio);
                if (xl) begin
                    if (th < ang_lo) th = ang_lo;
                    if (t < 655) t = 655;
                    r.region = RGN_DIST_BELOW;
                end else begin
                    if (th > ang_hi) th = ang_hi;
                    r.region = RGN_DIST_ABOVE;
                end
            end else if (yl || yh) begin
                i = int'(px >>> 16);
                j = yl ? 0 : int'(nr - 2);
                ratio = yl ? py : py - ((nr - 2) <<< 16);
                a = i * 64 + j; b = a + 1;
                th = lerp(angle_grid[a], angle_grid[b], ratio);
                t = lerp(time_grid[a], time_grid[b], ratio);
                if (yl) begin
                    if (th < ang_lo) th = ang_lo;
                    if (t < 655) t = 655;
                    r.region = RGN_HGT_BELOW;
                end else begin
                    r.region = RGN_HGT_ABOVE;
                end
            end else begin
                i = int'(px >>> 16); j = int'(py >>> 16);
                dx = px & 64'hFFFF; dy = py & 64'hFFFF;
                ex = 65536 - dx; ey = 65536 - dy;
                a = i * 64 + j;
                r0 = longint'(angle_grid[a]) * ex + longint'(angle_grid[a + 64]) * dx;
                r1 = longint'(angle_grid[a + 1]) * ex + longint'(angle_grid[a + 65]) * dx;
                th = (r0 * ey + r1 * dy) >>> 32;
                r0 = longint'(time_grid[a]) * ex + longint'(time_grid[a + 64]) * dx;
                r1 = longint'(time_grid[a + 1]) * ex + longint'(time_grid[a + 65]) * dx;
                t = (r0 * ey + r1 * dy) >>> 32;
                r.region = RGN_INTERIOR;
                if (t <= 0) begin
                    t = 655;
                end else begin
                    if (t > 655360) t = 655360;
                    if (th < ang_lo - 11438) th = ang_lo - 11438;
                    if (th > ang_hi + 11438) th = ang_hi + 11438;
                end
            end
            th = sat32(th);
            t = sat32(t);
            r.pitch_angle = th[31:0];
            r.flight_time = t[31:0];
            pending_res.push_back(r);
        endfunction

        function void check_res(t_res got);
            t_res want;
            if (pending_res.size() == 0) begin
                $display("%0t unexpected beat pitch %0d time %0d region %0d", $realtime,
                         got.pitch_angle, got.flight_time, got.region);
                errors++;
                return;
            end
            want = pending_res.pop_front();
            if (got.pitch_angle !== want.pitch_angle) begin
                $display("%0t pitch_angle expected %0d actual %0d", $realtime,
                         want.pitch_angle, got.pitch_angle);
                errors++;
            end
            if (got.flight_time !== want.flight_time) begin
                $display("%0t flight_time expected %0d actual %0d", $realtime,
                         want.flight_time, got.flight_time);
                errors++;
            end
            if (got.region !== want.region) begin
                $display("%0t region expected %0d actual %0d", $realtime,
                         want.region, got.region);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    t_cmd        i_cmd = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    t_res        o_res;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    aim_table_model sb;
    t_cmd           cmd_fifo[$];
    int             send_idle = 20;
    int             recv_idle = 78;
    int             quiet_cycles = 0;

    ballistic_table_bilinear_lookup_core uut (.*);

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                sb.note_cmd(i_cmd);
                void'(cmd_fifo.pop_front());
            end
            if (!(i_valid && o_stall)) begin
                if (cmd_fifo.size() > 0 && $urandom_range(99) >= send_idle) begin
                    i_valid <= 1'b1;
                    i_cmd <= cmd_fifo[0];
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_res(o_res);
        i_stall <= ($urandom_range(99) < recv_idle);
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= 20000) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, data);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (cmd_fifo.size() > 0 || i_valid || sb.pending_res.size() > 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    function automatic t_cmd grid_write(int c, int r, logic [31:0] ang, logic [31:0] tim);
        t_cmd x;
        x = CMD_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        x.opcode = OP_WRITE;
        x.dist_index = 6'(c);
        x.height_index = 6'(r);
        x.entry_angle = ang;
        x.entry_time = tim;
        return x;
    endfunction

    function automatic t_cmd grid_query(logic [31:0] d, logic [31:0] h);
        t_cmd x;
        x = CMD_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        x.opcode = OP_QUERY;
        x.target_dist = d;
        x.target_height = h;
        return x;
    endfunction

    // target from three steps below the grid to four steps past its last index, or fully random
    function automatic logic [31:0] near_grid(longint org, longint inv, longint n);
        longint u;
        if (n > 64) n = 64;
        if (n < 2) n = 2;
        u = longint'($urandom_range(0, 32'((n + 6) * 65536))) - 3 * 65536;
        if (inv == 0 || $urandom_range(99) < 12) return $urandom;
        return 32'(org + (u * 65536) / inv);
    endfunction

    function automatic logic [31:0] rand_angle();
        if ($urandom_range(9) == 0) return $urandom;
        return 32'($signed($urandom_range(0, 200000)) - 100000);
    endfunction

    function automatic logic [31:0] rand_time();
        int k;
        k = $urandom_range(19);
        if (k == 0) return $urandom;
        if (k == 1) return 32'(-$signed($urandom_range(0, 100000)));
        return $urandom_range(0, 800000);
    endfunction

    task automatic set_regs(logic [31:0] od, logic [31:0] oh, logic [31:0] id,
                            logic [31:0] ih, logic [31:0] nc, logic [31:0] nr,
                            logic [31:0] alo, logic [31:0] ahi);
        write_reg(REG_ORIGIN_DIST, od);
        write_reg(REG_ORIGIN_HEIGHT, oh);
        write_reg(REG_INV_STEP_DIST, id);
        write_reg(REG_INV_STEP_HGT, ih);
        write_reg(REG_COLS_USED, nc);
        write_reg(REG_ROWS_USED, nr);
        write_reg(REG_ANGLE_LOW, alo);
        write_reg(REG_ANGLE_HIGH, ahi);
    endtask

    task automatic run_phase(logic [31:0] od, logic [31:0] oh, logic [31:0] id,
                             logic [31:0] ih, logic [31:0] nc, logic [31:0] nr,
                             logic [31:0] alo, logic [31:0] ahi);
        set_regs(od, oh, id, ih, nc, nr, alo, ahi);
        repeat (100) begin
            if ($urandom_range(99) < 25)
                cmd_fifo.push_back(grid_write($urandom_range(15), $urandom_range(15),
                                              rand_angle(), rand_time()));
            else
                cmd_fifo.push_back(grid_query(near_grid(sb.org_d, sb.inv_d, sb.n_cols),
                                              near_grid(sb.org_h, sb.inv_h, sb.n_rows)));
        end
        wait_idle();
    endtask

    initial begin
        sb = new();
        sb.clear_regs();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // queries read only a 16 by 16 grid, so load all of it
        set_regs(0, 0, 65536, 65536, 16, 16, 0, 0);
        for (int c = 0; c < 16; c++)
            for (int r = 0; r < 16; r++)
                cmd_fifo.push_back(grid_write(c, r, rand_angle(), rand_time()));

        // negative time cell block and saturated block
        for (int k = 0; k < 4; k++) begin
            cmd_fifo.push_back(grid_write(10 + k / 2, 10 + k % 2, 32'h7FFFFFFF, 32'h80000000));
            cmd_fifo.push_back(grid_write(12 + k / 2, 12 + k % 2, 32'h80000000, 32'h7FFFFFFF));
        end
        cmd_fifo.push_back(grid_query(32'h000A8000, 32'h000A8000));
        cmd_fifo.push_back(grid_query(32'h000C8000, 32'h000C4000));
        cmd_fifo.push_back(grid_query(-32'sh50000, -32'sh50000));
        cmd_fifo.push_back(grid_query(32'h00640000, 32'h00640000));
        cmd_fifo.push_back(grid_query(32'h000F0000, 32'h000F0000));
        cmd_fifo.push_back(grid_query(-32'sh30000, 32'h00078000));
        cmd_fifo.push_back(grid_query(32'h00140000, 32'h00078000));
        cmd_fifo.push_back(grid_query(32'h00078000, -32'sh20000));
        cmd_fifo.push_back(grid_query(32'h00078000, 32'h00140000));
        cmd_fifo.push_back(grid_query(32'h0, 32'h0));
        cmd_fifo.push_back(grid_query(32'h80000000, 32'h7FFFFFFF));
        cmd_fifo.push_back(grid_query(32'h7FFFFFFF, 32'h80000000));
        cmd_fifo.push_back(grid_query(32'h000EFFFF, 32'h000EFFFF));
        wait_idle();

        run_phase(0, 0, 65536, 65536, 16, 16, -32'sd20000, 32'sd30000);
        run_phase($urandom, $urandom, 32768, 131072, 2, 2, 32'h80000000, 32'h7FFFFFFF);
        send_idle = 78;
        recv_idle = 20;
        run_phase($urandom, $urandom, 32'hFFFFFFFF, 32'h80000000, 1, 0,
                  32'h7FFFFFFF, 32'h80000000);
        run_phase($urandom, $urandom, 40000, 90000, 13, 9, -32'sd50000, 32'sd50000);
        send_idle = 0;
        recv_idle = 0;
        run_phase(0, 0, 65536, 65536, 16, 16, 0, 0);

        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
